// ===== src/cau_pkg.sv =====
// shared types, constants and the divider step and saturation functions for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int PART_W  = 16;
    localparam int PROD_W  = 2 * PART_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIV_W   = 48;
    localparam int QUO_W   = 16;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    localparam logic signed [PART_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [PART_W-1:0] SAT_MIN = -16'sh8000;

    // one result part travelling through the divider
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [DIV_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } t_div_lane;

    // one divider stage: both parts share the divisor
    typedef struct packed {
        logic              vld;
        logic              dz;
        logic [DIV_W-1:0]  den;
        t_div_lane         re;
        t_div_lane         im;
    } t_div_stage;

    // one restoring step for quotient bit bitpos
    function automatic t_div_lane div_step(t_div_lane l, logic [DIV_W-1:0] den,
                                           logic [3:0] bitpos);
        t_div_lane        o;
        logic [DIV_W-1:0] trial;
        o     = l;
        trial = den << bitpos;
        if (l.rem >= trial) begin
            o.rem         = l.rem - trial;
            o.quo[bitpos] = 1'b1;
        end
        return o;
    endfunction

    // sign, clamp and narrow a finished quotient
    function automatic logic [PART_W:0] sat_part(t_div_lane l);
        logic [PART_W-1:0] v;
        logic              s;
        s = 1'b0;
        if (l.neg) begin
            if (l.ovf || l.quo > 16'd32768) begin
                v = SAT_MIN;
                s = 1'b1;
            end else begin
                v = 16'(-l.quo);
            end
        end else begin
            if (l.ovf || l.quo > 16'd32767) begin
                v = SAT_MAX;
                s = 1'b1;
            end else begin
                v = l.quo;
            end
        end
        return {s, v};
    endfunction

endpackage

// ===== src/complex_arith_unit_core.sv =====
// one transaction per cycle while the output is not stalled;
// the pipeline holds products, sums, magnitude, 16 restoring divide
// stages (one quotient bit each) and an output register, all stalled together
// reset (synchronous, active low) clears every stage valid bit; payload is not reset
// top level of the complex arithmetic unit, uses cau_pkg
module complex_arith_unit_core
    import cau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_func,
    input  logic signed [PART_W-1:0] i_a_real,
    input  logic signed [PART_W-1:0] i_a_imag,
    input  logic signed [PART_W-1:0] i_b_real,
    input  logic signed [PART_W-1:0] i_b_imag,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [PART_W-1:0] o_res_real,
    output logic signed [PART_W-1:0] o_res_imag,
    output logic                     o_saturated,
    output logic                     o_div_zero
);

    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: products and add/sub sums
    logic                     r_v1;
    logic [1:0]               r_func1;
    logic                     r_bz1;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [PART_W:0]   r_as_re, r_as_im;

    // stage 2: combined sums and squared magnitude
    logic                     r_v2;
    logic [1:0]               r_func2;
    logic                     r_dz2;
    logic signed [SUM_W-1:0]  r_s_re, r_s_im;
    logic [PROD_W-1:0]        r_mag2;

    // stage 3: sign and magnitude
    logic                     r_v3;
    logic [1:0]               r_func3;
    logic                     r_dz3;
    logic                     r_neg_re, r_neg_im;
    logic [SUM_W-1:0]         r_a_re, r_a_im;
    logic [PROD_W-1:0]        r_mag3;

    // divider stages
    t_div_stage r_stg [0:DIV_STEPS];
    t_div_stage n_stg [0:DIV_STEPS];

    // signed and clamped parts feeding the output register
    logic [PART_W:0] w_out_re, w_out_im;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func1 <= i_func;
            r_bz1   <= (i_b_real == '0) && (i_b_imag == '0);
            r_p_rr  <= PROD_W'(i_a_real) * PROD_W'(i_b_real);
            r_p_ii  <= PROD_W'(i_a_imag) * PROD_W'(i_b_imag);
            r_p_ri  <= PROD_W'(i_a_real) * PROD_W'(i_b_imag);
            r_p_ir  <= PROD_W'(i_a_imag) * PROD_W'(i_b_real);
            r_p_bb  <= PROD_W'(i_b_real) * PROD_W'(i_b_real);
            r_p_cc  <= PROD_W'(i_b_imag) * PROD_W'(i_b_imag);
            if (i_func == FUNC_SUB) begin
                r_as_re <= 17'(i_a_real) - 17'(i_b_real);
                r_as_im <= 17'(i_a_imag) - 17'(i_b_imag);
            end else begin
                r_as_re <= 17'(i_a_real) + 17'(i_b_real);
                r_as_im <= 17'(i_a_imag) + 17'(i_b_imag);
            end
        end
    end

    // stage 2 sum selection
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func2 <= r_func1;
            r_dz2   <= (r_func1 == FUNC_DIV) && r_bz1;
            r_mag2  <= PROD_W'(r_p_bb) + PROD_W'(r_p_cc);
            case (r_func1)
                FUNC_MUL: begin
                    r_s_re <= SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
                    r_s_im <= SUM_W'(r_p_ri) + SUM_W'(r_p_ir);
                end
                FUNC_DIV: begin
                    r_s_re <= SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
                    r_s_im <= SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
                end
                default: begin
                    r_s_re <= SUM_W'(r_as_re);
                    r_s_im <= SUM_W'(r_as_im);
                end
            endcase
        end
    end

    // stage 3 absolute values
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_func3  <= r_func2;
            r_dz3    <= r_dz2;
            r_mag3   <= r_mag2;
            r_neg_re <= r_s_re[SUM_W-1];
            r_neg_im <= r_s_im[SUM_W-1];
            r_a_re   <= r_s_re[SUM_W-1] ? SUM_W'(-r_s_re) : SUM_W'(r_s_re);
            r_a_im   <= r_s_im[SUM_W-1] ? SUM_W'(-r_s_im) : SUM_W'(r_s_im);
        end
    end

    // divider setup: dividend with rounding offset for multiply and divide, divisor, overflow check
    logic [DIV_W-1:0] w_x_re, w_x_im, w_den;
    always_comb begin
        case (r_func3)
            FUNC_MUL: begin
                w_den  = DIV_W'(256);
                w_x_re = DIV_W'(r_a_re) + DIV_W'(128);
                w_x_im = DIV_W'(r_a_im) + DIV_W'(128);
            end
            FUNC_DIV: begin
                w_den  = DIV_W'(r_mag3);
                w_x_re = (DIV_W'(r_a_re) << 8) + DIV_W'(r_mag3 >> 1);
                w_x_im = (DIV_W'(r_a_im) << 8) + DIV_W'(r_mag3 >> 1);
            end
            default: begin
                w_den  = DIV_W'(1);
                w_x_re = DIV_W'(r_a_re);
                w_x_im = DIV_W'(r_a_im);
            end
        endcase
        n_stg[0].vld    = r_v3;
        n_stg[0].dz     = r_dz3;
        n_stg[0].den    = w_den;
        n_stg[0].re.neg = r_neg_re;
        n_stg[0].im.neg = r_neg_im;
        n_stg[0].re.ovf = w_x_re >= (w_den << QUO_W);
        n_stg[0].im.ovf = w_x_im >= (w_den << QUO_W);
        n_stg[0].re.rem = w_x_re;
        n_stg[0].im.rem = w_x_im;
        n_stg[0].re.quo = '0;
        n_stg[0].im.quo = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_stg[k+1]    = r_stg[k];
            n_stg[k+1].re = div_step(r_stg[k].re, r_stg[k].den, 4'(DIV_STEPS - 1 - k));
            n_stg[k+1].im = div_step(r_stg[k].im, r_stg[k].den, 4'(DIV_STEPS - 1 - k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stg[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // final sign, clamp and divide-by-zero override
    assign w_out_re = sat_part(r_stg[DIV_STEPS].re);
    assign w_out_im = sat_part(r_stg[DIV_STEPS].im);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_stg[DIV_STEPS].dz) begin
                o_res_real  <= '0;
                o_res_imag  <= '0;
                o_saturated <= 1'b0;
                o_div_zero  <= 1'b1;
            end else begin
                o_res_real  <= w_out_re[PART_W-1:0];
                o_res_imag  <= w_out_im[PART_W-1:0];
                o_saturated <= w_out_re[PART_W] | w_out_im[PART_W];
                o_div_zero  <= 1'b0;
            end
        end
    end

    // valid chain for the front stages and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_stg[DIV_STEPS].vld;
        end
    end

endmodule

// ===== src/cau_checker.sv =====
// port-level checker for complex_arith_unit_core, attached by bind
// uses cau_pkg
module cau_checker
    import cau_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_stall,
    input logic                     o_valid,
    input logic signed [PART_W-1:0] o_res_real,
    input logic signed [PART_W-1:0] o_res_imag,
    input logic                     o_saturated,
    input logic                     o_div_zero
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_real) && $stable(o_res_imag))
        else $error("stalled result changed");

    // divide by zero gives a clean zero
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_real == '0 && o_res_imag == '0 && !o_saturated)
        else $error("divide by zero result not zero");

    // a clamped result sits on a rail
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_res_real == SAT_MAX || o_res_real == SAT_MIN ||
            o_res_imag == SAT_MAX || o_res_imag == SAT_MIN)
        else $error("saturated flag without clamped part");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_valid     (o_valid),
    .o_res_real  (o_res_real),
    .o_res_imag  (o_res_imag),
    .o_saturated (o_saturated),
    .o_div_zero  (o_div_zero)
);
